>>> rtl/core/fpr_pkg.sv
// shared constants and types for the fifo page replacement block
`timescale 1ns / 1ps

package fpr_pkg;

  localparam int FRAMES    = 8;
  localparam int PAGE_W    = 16;
  localparam int CNT_W     = 16;
  localparam int CFG_W     = 4;
  localparam int PTR_W     = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int NUM_W     = $clog2(FRAMES + 1);
  localparam int CMP_W     = (NUM_W > CFG_W) ? NUM_W : CFG_W;
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 1;

  localparam logic [CFG_W-1:0]  CFG_FRAMES_RESET = CFG_W'(8);
  localparam logic [CNT_W-1:0]  COUNT_MAX        = '1;
  localparam logic [APB_AW-1:0] ADDR_FRAMES      = '0;

  typedef logic [PAGE_W-1:0] page_t;

  // controller to datapath
  typedef struct packed {
    logic load;     // capture the incoming reference
    logic commit;   // evaluate held reference, update frames, load result
    logic cfg_we;   // write frames_in_use
  } fpr_cmd_t;

endpackage

>>> rtl/core/fpr_chan_if.sv
// valid/ready channel interfaces for page references and results
`timescale 1ns / 1ps

interface fpr_req_if;
  logic                 valid;
  logic                 ready;
  logic [fpr_pkg::PAGE_W-1:0] page_number;
  logic                 last_in_string;

  modport source (output valid, page_number, last_in_string, input ready);
  modport sink   (input valid, page_number, last_in_string, output ready);
endinterface

interface fpr_rsp_if;
  logic                 valid;
  logic                 ready;
  logic                 page_fault;
  logic                 evicted_valid;
  logic [fpr_pkg::PAGE_W-1:0] evicted_page;
  logic [fpr_pkg::CNT_W-1:0]  fault_total;

  modport source (output valid, page_fault, evicted_valid, evicted_page, fault_total,
                  input ready);
  modport sink   (input valid, page_fault, evicted_valid, evicted_page, fault_total,
                  output ready);
endinterface

>>> rtl/core/fifo_page_replacement.sv
// top level of the fifo page replacement block: channels, register port, control and datapath
// flow: an accepted reference waits in the hold stage, then is evaluated into the result register
// throughput: one reference per cycle while results are taken; the result register
//   holds a finished result while the next reference is captured and waits in the hold stage
// reset (rst, synchronous, active high): all frames empty, pointer and fault count zero,
//   frames_in_use back to 8, no result pending; no clearing pass is needed
`timescale 1ns / 1ps

module fifo_page_replacement (
  input  logic                        clk,
  input  logic                        rst,
  // register port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fpr_pkg::APB_AW-1:0]  paddr,
  input  logic [fpr_pkg::APB_DW-1:0]  pwdata,
  output logic [fpr_pkg::APB_DW-1:0]  prdata,
  output logic                        pready,
  // page references in, replacement results out
  fpr_req_if.sink                     page_ref,
  fpr_rsp_if.source                   replace_result
);
  import fpr_pkg::*;

  fpr_cmd_t          cmd;
  logic              cfg_write;
  logic [CFG_W-1:0]  frames_in_use;

  // register port is always ready; a write lands in the access phase
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr == ADDR_FRAMES);

  // read back frames_in_use, anything else reads zero
  assign prdata = (paddr == ADDR_FRAMES) ? APB_DW'(frames_in_use) : '0;

  // controller: hands the reference into the hold stage and the result register
  fpr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (page_ref.valid),
    .in_ready  (page_ref.ready),
    .out_valid (replace_result.valid),
    .out_ready (replace_result.ready),
    .cfg_write (cfg_write),
    .cmd       (cmd)
  );

  // datapath: lookup over the frames in use, fifo replacement and fault count
  fpr_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .cfg_wdata      (pwdata[CFG_W-1:0]),
    .frames_in_use  (frames_in_use),
    .page_number    (page_ref.page_number),
    .last_in_string (page_ref.last_in_string),
    .page_fault     (replace_result.page_fault),
    .evicted_valid  (replace_result.evicted_valid),
    .evicted_page   (replace_result.evicted_page),
    .fault_total    (replace_result.fault_total)
  );

endmodule

>>> rtl/core/fpr_ctrl.sv
// controller: reference hold and result register handshake
`timescale 1ns / 1ps

module fpr_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  logic              cfg_write,
  output fpr_pkg::fpr_cmd_t cmd
);
  import fpr_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EVAL = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;
  logic commit;
  logic load;

  // result slot free when empty or being drained this cycle
  assign commit   = (state == ST_EVAL) && (!out_valid || out_ready);
  assign in_ready = (state == ST_IDLE) || commit;
  assign load     = in_valid && in_ready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (load) state_next = ST_EVAL;
      end
      ST_EVAL: begin
        if (commit && !load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (commit) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assign cmd.load   = load;
  assign cmd.commit = commit;
  assign cmd.cfg_we = cfg_write;

endmodule

>>> rtl/core/fpr_dp.sv
// datapath: frame table, lookup row, replace pointer, fault counter, result register
`timescale 1ns / 1ps

module fpr_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  fpr_pkg::fpr_cmd_t          cmd,
  input  logic [fpr_pkg::CFG_W-1:0]  cfg_wdata,
  output logic [fpr_pkg::CFG_W-1:0]  frames_in_use,
  input  logic [fpr_pkg::PAGE_W-1:0] page_number,
  input  logic                       last_in_string,
  output logic                       page_fault,
  output logic                       evicted_valid,
  output logic [fpr_pkg::PAGE_W-1:0] evicted_page,
  output logic [fpr_pkg::CNT_W-1:0]  fault_total
);
  import fpr_pkg::*;

  page_t              frame_page [FRAMES];
  logic [FRAMES-1:0]  frame_valid;
  logic [PTR_W-1:0]   replace_pointer;
  logic [CNT_W-1:0]   fault_count;

  page_t              hold_page;
  logic               hold_last;

  logic [CMP_W-1:0]   cfg_ext;
  logic [CMP_W-1:0]   active;
  logic [FRAMES-1:0]  match;
  logic               hit;
  logic [PTR_W-1:0]   slot;
  logic [CMP_W-1:0]   slot_inc;
  logic [PTR_W-1:0]   ptr_adv;
  logic [CNT_W-1:0]   count_inc;

  assign cfg_ext = CMP_W'(frames_in_use);

  // zero acts as one, anything above the table size acts as the table size
  always_comb begin
    if (cfg_ext == '0) active = CMP_W'(1);
    else if (cfg_ext > CMP_W'(FRAMES)) active = CMP_W'(FRAMES);
    else active = cfg_ext;
  end

  // compare row over the frames in use
  always_comb begin
    for (int i = 0; i < FRAMES; i++) begin
      match[i] = frame_valid[i] && (CMP_W'(i) < active) && (frame_page[i] == hold_page);
    end
  end
  assign hit = |match;

  // stale pointer past the frames in use restarts at frame 0
  assign slot      = (CMP_W'(replace_pointer) >= active) ? '0 : replace_pointer;
  assign slot_inc  = CMP_W'(slot) + CMP_W'(1);
  assign ptr_adv   = (slot_inc >= active) ? '0 : slot_inc[PTR_W-1:0];
  assign count_inc = (fault_count == COUNT_MAX) ? fault_count : fault_count + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_in_use   <= CFG_FRAMES_RESET;
      frame_valid     <= '0;
      replace_pointer <= '0;
      fault_count     <= '0;
    end else begin
      if (cmd.cfg_we) frames_in_use <= cfg_wdata;
      if (cmd.commit) begin
        if (hold_last) begin
          frame_valid     <= '0;
          replace_pointer <= '0;
          fault_count     <= '0;
        end else if (!hit) begin
          frame_valid[slot] <= 1'b1;
          replace_pointer   <= ptr_adv;
          fault_count       <= count_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hold_page <= page_number;
      hold_last <= last_in_string;
    end
    if (cmd.commit) begin
      if (!hit) frame_page[slot] <= hold_page;
      page_fault    <= !hit;
      evicted_valid <= !hit && frame_valid[slot];
      evicted_page  <= (!hit && frame_valid[slot]) ? frame_page[slot] : '0;
      fault_total   <= hit ? fault_count : count_inc;
    end
  end

endmodule
